>>> hdl/ffua_pkg.sv
package ffua_pkg;

    localparam int MAP_UNITS_DEF  = 1024;
    localparam int OWNER_BITS_DEF = 8;

    localparam int OWNER_ID_W  = 8;
    localparam int REQ_UNITS_W = 11;
    localparam int STATUS_W    = 3;
    localparam int START_W     = 10;
    localparam int HELD_W      = 11;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic fill;
        logic load_resp;
    } ffua_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic need_fill;
        logic fill_done;
    } ffua_sts_t;

endpackage

>>> hdl/first_fit_unit_allocator_unit.sv
// Channel   Handshake              Payload
// request   req_valid/req_ready    req_type, owner_id, req_units
// response  rsp_valid/rsp_ready    status, start_index, held_units
//
// One request at a time. A request scans the owner map one entry per cycle
// through the map's single read port, ending early when an allocation finds
// the owner or a free passes the owner's first run. A decision state follows;
// a new allocation then writes req_units entries, one per cycle, before the
// response load. After reset a clearing pass writes every map entry free with
// req_ready low. A response waiting on rsp_ready does not block the next request.
module first_fit_unit_allocator_unit #(
    parameter int MAP_UNITS  = ffua_pkg::MAP_UNITS_DEF,
    parameter int OWNER_BITS = ffua_pkg::OWNER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic                               req_type,
    input  logic [ffua_pkg::OWNER_ID_W-1:0]    owner_id,
    input  logic [ffua_pkg::REQ_UNITS_W-1:0]   req_units,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [ffua_pkg::STATUS_W-1:0]      status,
    output logic [ffua_pkg::START_W-1:0]       start_index,
    output logic [ffua_pkg::HELD_W-1:0]        held_units
);
    import ffua_pkg::*;

    ffua_cmd_t cmd;
    ffua_sts_t sts;

    ffua_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffua_dpath #(
        .MAP_UNITS  (MAP_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .owner_id    (owner_id),
        .req_units   (req_units),
        .status      (status),
        .start_index (start_index),
        .held_units  (held_units)
    );

endmodule

>>> hdl/ffua_ctrl.sv
module ffua_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  ffua_pkg::ffua_sts_t sts,
    output ffua_pkg::ffua_cmd_t cmd
);
    import ffua_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       can_load;

    assign can_load  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.clear     = (state_reg == S_CLEAR);
        cmd.start     = (state_reg == S_IDLE) && req_valid;
        cmd.scan      = (state_reg == S_SCAN);
        cmd.fill      = (state_reg == S_FILL);
        cmd.load_resp = (state_reg == S_RESP) && can_load;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = sts.need_fill ? S_FILL : S_RESP;
            end
            S_FILL:
            begin
                if (sts.fill_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (can_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_resp)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> hdl/ffua_dpath.sv
module ffua_dpath #(
    parameter int MAP_UNITS  = ffua_pkg::MAP_UNITS_DEF,
    parameter int OWNER_BITS = ffua_pkg::OWNER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffua_pkg::ffua_cmd_t                cmd,
    output ffua_pkg::ffua_sts_t                sts,
    input  logic                               req_type,
    input  logic [ffua_pkg::OWNER_ID_W-1:0]    owner_id,
    input  logic [ffua_pkg::REQ_UNITS_W-1:0]   req_units,
    output logic [ffua_pkg::STATUS_W-1:0]      status,
    output logic [ffua_pkg::START_W-1:0]       start_index,
    output logic [ffua_pkg::HELD_W-1:0]        held_units
);
    import ffua_pkg::*;

    localparam int AW = $clog2(MAP_UNITS);
    localparam int CW = $clog2(MAP_UNITS + 1);
    localparam int WW = (CW > REQ_UNITS_W) ? CW : REQ_UNITS_W;
    localparam int EW = OWNER_BITS + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_UNITS - 1);

    // entry: used flag on top, owner below
    logic [EW-1:0] mem [MAP_UNITS];

    logic                   kind_reg;
    logic [OWNER_BITS-1:0]  owner_reg;
    logic [REQ_UNITS_W-1:0] want_reg;

    logic [AW-1:0] addr_reg,    addr_next;
    logic          issued_reg,  issued_next;
    logic          rvld_reg;
    logic [EW-1:0] rdata_reg;
    logic [AW-1:0] ridx_reg;

    logic          found_reg,     found_next;
    logic [AW-1:0] pos_reg,       pos_next;
    logic          fit_reg,       fit_next;
    logic [AW-1:0] fit_start_reg, fit_start_next;
    logic [CW-1:0] run_reg,       run_next;
    logic [AW:0]   run_start_reg, run_start_next;
    logic [CW-1:0] free_cnt_reg,  free_cnt_next;
    logic [CW-1:0] fill_cnt_reg,  fill_cnt_next;
    logic [CW-1:0] held_reg,      held_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [START_W-1:0]  start_reg,  start_next;

    logic          issue;
    logic          eval;
    logic          hit;
    logic          last;
    logic          want_ok;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [CW-1:0] run_inc;

    assign issue   = cmd.scan && !issued_reg;
    assign eval    = cmd.scan && rvld_reg;
    assign hit     = rdata_reg[OWNER_BITS] && (rdata_reg[OWNER_BITS-1:0] == owner_reg);
    assign last    = (ridx_reg == LAST_ADDR);
    assign want_ok = (want_reg != '0) && (WW'(want_reg) <= WW'(MAP_UNITS));
    assign run_inc = run_reg + CW'(1);

    always_comb
    begin
        addr_next      = addr_reg;
        issued_next    = issued_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        fit_next       = fit_reg;
        fit_start_next = fit_start_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        free_cnt_next  = free_cnt_reg;
        fill_cnt_next  = fill_cnt_reg;
        held_next      = held_reg;
        status_next    = status_reg;
        start_next     = start_reg;
        we             = 1'b0;
        waddr          = addr_reg;
        wdata          = '0;

        sts.clear_done = cmd.clear && (addr_reg == LAST_ADDR);
        sts.scan_done  = 1'b0;
        sts.need_fill  = (kind_reg == REQ_ALLOC) && !found_reg && fit_reg;
        sts.fill_done  = (WW'(fill_cnt_reg) + WW'(1)) == WW'(want_reg);

        if (cmd.start)
        begin
            addr_next      = '0;
            issued_next    = 1'b0;
            found_next     = 1'b0;
            pos_next       = '0;
            fit_next       = 1'b0;
            fit_start_next = '0;
            run_next       = '0;
            run_start_next = '0;
            free_cnt_next  = '0;
            fill_cnt_next  = '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                we        = 1'b1;
                waddr     = addr_reg;
                addr_next = addr_reg + AW'(1);
            end

            if (issue)
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR)
                    issued_next = 1'b1;
            end

            if (eval)
            begin
                if (kind_reg == REQ_ALLOC)
                begin
                    if (hit)
                    begin
                        found_next    = 1'b1;
                        pos_next      = ridx_reg;
                        sts.scan_done = 1'b1;
                    end
                    else if (want_ok && !fit_reg)
                    begin
                        if (rdata_reg[OWNER_BITS])
                        begin
                            run_next       = '0;
                            run_start_next = {1'b0, ridx_reg} + (AW + 1)'(1);
                        end
                        else
                        begin
                            run_next = run_inc;
                            // first fit: lock the run that reaches the wanted size
                            if (WW'(run_inc) == WW'(want_reg))
                            begin
                                fit_next       = 1'b1;
                                fit_start_next = run_start_reg[AW-1:0];
                            end
                        end
                    end
                    if (last)
                        sts.scan_done = 1'b1;
                end
                else
                begin
                    if (hit)
                    begin
                        found_next    = 1'b1;
                        free_cnt_next = free_cnt_reg + CW'(1);
                        if (!found_reg)
                            pos_next = ridx_reg;
                        we    = 1'b1;
                        waddr = ridx_reg;
                        wdata = '0;
                    end
                    // stop at the end of the owner's first run
                    if (last || (found_reg && !hit))
                        sts.scan_done = 1'b1;
                end
            end

            if (cmd.fill)
            begin
                we            = 1'b1;
                waddr         = AW'(CW'(fit_start_reg) + fill_cnt_reg);
                wdata         = {1'b1, owner_reg};
                fill_cnt_next = fill_cnt_reg + CW'(1);
            end

            if (cmd.load_resp)
            begin
                if (kind_reg == REQ_ALLOC)
                begin
                    if (found_reg)
                    begin
                        status_next = ST_HELD;
                        start_next  = START_W'(pos_reg);
                    end
                    else if (fit_reg)
                    begin
                        status_next = ST_NEW;
                        start_next  = START_W'(fit_start_reg);
                        held_next   = held_reg + CW'(want_reg);
                    end
                    else
                    begin
                        status_next = ST_NOSPACE;
                        start_next  = '0;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        status_next = ST_FREED;
                        start_next  = START_W'(pos_reg);
                        held_next   = held_reg - free_cnt_reg;
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                        start_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (issue)
        begin
            rdata_reg <= mem[addr_reg];
            ridx_reg  <= addr_reg;
        end
        if (cmd.start)
        begin
            kind_reg  <= req_type;
            owner_reg <= OWNER_BITS'(owner_id);
            want_reg  <= req_units;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            issued_reg    <= 1'b0;
            rvld_reg      <= 1'b0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            fit_reg       <= 1'b0;
            fit_start_reg <= '0;
            run_reg       <= '0;
            run_start_reg <= '0;
            free_cnt_reg  <= '0;
            fill_cnt_reg  <= '0;
            held_reg      <= '0;
            status_reg    <= '0;
            start_reg     <= '0;
        end
        else
        begin
            addr_reg      <= addr_next;
            issued_reg    <= issued_next;
            rvld_reg      <= issue;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            fit_reg       <= fit_next;
            fit_start_reg <= fit_start_next;
            run_reg       <= run_next;
            run_start_reg <= run_start_next;
            free_cnt_reg  <= free_cnt_next;
            fill_cnt_reg  <= fill_cnt_next;
            held_reg      <= held_next;
            status_reg    <= status_next;
            start_reg     <= start_next;
        end
    end

    assign status      = status_reg;
    assign start_index = start_reg;
    assign held_units  = HELD_W'(held_reg);

endmodule
